// ----- rtl/hsvlc_pkg.sv -----
// shared types and constants for the hsv light color controller
`default_nettype none

package hsvlc_pkg;

    // attribute opcodes
    localparam logic [1:0] OP_ONOFF = 2'd0;
    localparam logic [1:0] OP_LEVEL = 2'd1;
    localparam logic [1:0] OP_HUE   = 2'd2;
    localparam logic [1:0] OP_SAT   = 2'd3;

    // attribute values after reset
    localparam logic [7:0] RESET_LEVEL = 8'd128;
    localparam logic [7:0] RESET_HUE   = 8'd0;
    localparam logic [7:0] RESET_SAT   = 8'd254;

    // default depth of the queue between front and back
    localparam int QDEPTH = 2;

    // deg = h*360/254 as h*ceil(2^23*180/127)>>23, exact for 8-bit h
    localparam logic [23:0] DEG_RECIP = 24'd11889366;
    localparam int          DEG_SHIFT = 23;
    localparam int          DEG_W     = 9;

    // region = deg/60 as deg*547>>15, exact for deg up to 361
    localparam logic [9:0]  REG_RECIP = 10'd547;
    localparam int          REG_SHIFT = 15;
    localparam int          REG_W     = 3;

    localparam logic [8:0]  REGION_SPAN = 9'd60;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    // attribute snapshot handed from front to back
    typedef struct packed {
        logic       lamp_on;
        logic [7:0] level;
        logic [7:0] hue;
        logic [7:0] sat;
    } t_snap;

endpackage

`default_nettype wire

// ----- rtl/hsvlc_if.sv -----
// handshake channels: attribute writes in, colors out
`default_nettype none

interface hsvlc_attr_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] attr_value;

    modport source (output valid, output opcode, output attr_value, input ready);
    modport sink   (input valid, input opcode, input attr_value, output ready);
endinterface

interface hsvlc_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsvlc_front.sv -----
// front end: takes attribute writes, keeps the attributes, queues snapshots
`default_nettype none

module hsvlc_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    hsvlc_attr_if.sink       i_attr,
    input  wire              i_full,
    output logic             o_push,
    output hsvlc_pkg::t_snap o_snap
);

    hsvlc_pkg::t_snap r_attr;
    hsvlc_pkg::t_snap n_attr;
    logic             accept;

    assign i_attr.ready = !i_full;
    assign accept       = i_attr.valid && !i_full;

    always_comb begin
        n_attr = r_attr;
        if (accept) begin
            unique case (i_attr.opcode)
                hsvlc_pkg::OP_ONOFF: n_attr.lamp_on = (i_attr.attr_value != 8'd0);
                hsvlc_pkg::OP_LEVEL: n_attr.level   = i_attr.attr_value;
                hsvlc_pkg::OP_HUE:   n_attr.hue     = i_attr.attr_value;
                hsvlc_pkg::OP_SAT:   n_attr.sat     = i_attr.attr_value;
                default:             n_attr         = r_attr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr.lamp_on <= 1'b0;
            r_attr.level   <= hsvlc_pkg::RESET_LEVEL;
            r_attr.hue     <= hsvlc_pkg::RESET_HUE;
            r_attr.sat     <= hsvlc_pkg::RESET_SAT;
        end else begin
            r_attr <= n_attr;
        end
    end

    // every write yields a color from the updated attributes
    assign o_push = accept;
    assign o_snap = n_attr;

endmodule

`default_nettype wire

// ----- rtl/hsvlc_queue.sv -----
// small fifo of attribute snapshots between front and back
`default_nettype none

module hsvlc_queue #(
    parameter int DEPTH = hsvlc_pkg::QDEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  hsvlc_pkg::t_snap i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output hsvlc_pkg::t_snap o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    hsvlc_pkg::t_snap r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hsvlc_back.sv -----
// back end: sequenced hsv to rgb conversion and the output register
`default_nettype none

module hsvlc_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  hsvlc_pkg::t_snap i_data,
    output logic             o_pop,
    hsvlc_color_if.source    o_color
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEG  = 3'd1;
    localparam logic [2:0] S_REG  = 3'd2;
    localparam logic [2:0] S_FRAC = 3'd3;
    localparam logic [2:0] S_SF   = 3'd4;
    localparam logic [2:0] S_QT   = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;

    localparam int DW = hsvlc_pkg::DEG_W;
    localparam int RW = hsvlc_pkg::REG_W;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    hsvlc_pkg::t_snap r_snap;
    logic [DW-1:0]    r_deg;
    logic [RW-1:0]    r_region;
    logic [7:0]       r_frac;
    logic [7:0]       r_p;
    logic [7:0]       r_sf;
    logic [7:0]       r_st;
    logic [7:0]       r_q;
    logic [7:0]       r_t;
    logic             r_out_valid;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;

    logic             wb_fire;
    logic             load;
    logic [31:0]      deg_prod;
    logic [18:0]      reg_prod;
    logic [8:0]       rem_full;
    logic [9:0]       frac_prod;
    logic [15:0]      p_prod;
    logic [15:0]      sf_prod;
    logic [15:0]      st_prod;
    logic [15:0]      q_prod;
    logic [15:0]      t_prod;
    logic [7:0]       n_red;
    logic [7:0]       n_green;
    logic [7:0]       n_blue;

    assign wb_fire = (r_state == S_WB) && (!r_out_valid || o_color.ready);
    assign load    = i_valid && ((r_state == S_IDLE) || wb_fire);
    assign o_pop   = load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = i_valid ? S_DEG : S_IDLE;
            S_DEG:   n_state = S_REG;
            S_REG:   n_state = S_FRAC;
            S_FRAC:  n_state = S_SF;
            S_SF:    n_state = S_QT;
            S_QT:    n_state = S_WB;
            S_WB:    n_state = wb_fire ? (i_valid ? S_DEG : S_IDLE) : S_WB;
            default: n_state = S_IDLE;
        endcase
    end

    // constant multiplies by reciprocals stand in for the divides
    assign deg_prod  = 32'(r_snap.hue) * 32'(hsvlc_pkg::DEG_RECIP);
    assign reg_prod  = 19'(r_deg) * 19'(hsvlc_pkg::REG_RECIP);
    assign rem_full  = r_deg - 9'(r_region) * hsvlc_pkg::REGION_SPAN;
    assign frac_prod = 10'(rem_full[5:0]) * 10'd17;
    assign p_prod    = 16'(r_snap.level) * 16'(hsvlc_pkg::FULL_SCALE - r_snap.sat);
    assign sf_prod   = 16'(r_snap.sat) * 16'(r_frac);
    assign st_prod   = 16'(r_snap.sat) * 16'(hsvlc_pkg::FULL_SCALE - r_frac);
    assign q_prod    = 16'(r_snap.level) * 16'(hsvlc_pkg::FULL_SCALE - r_sf);
    assign t_prod    = 16'(r_snap.level) * 16'(hsvlc_pkg::FULL_SCALE - r_st);

    always_comb begin
        case (r_region)
            3'd0:    begin n_red = r_snap.level; n_green = r_t;          n_blue = r_p;          end
            3'd1:    begin n_red = r_q;          n_green = r_snap.level; n_blue = r_p;          end
            3'd2:    begin n_red = r_p;          n_green = r_snap.level; n_blue = r_t;          end
            3'd3:    begin n_red = r_p;          n_green = r_q;          n_blue = r_snap.level; end
            3'd4:    begin n_red = r_t;          n_green = r_p;          n_blue = r_snap.level; end
            // region 6 (hue at the top of the range) folds into region 5
            default: begin n_red = r_snap.level; n_green = r_p;          n_blue = r_q;          end
        endcase
        if (!r_snap.lamp_on) begin
            n_red   = 8'd0;
            n_green = 8'd0;
            n_blue  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_color.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_snap <= i_data;
        end
        if (r_state == S_DEG) begin
            r_deg <= deg_prod[hsvlc_pkg::DEG_SHIFT +: DW];
        end
        if (r_state == S_REG) begin
            r_region <= reg_prod[hsvlc_pkg::REG_SHIFT +: RW];
        end
        if (r_state == S_FRAC) begin
            r_frac <= frac_prod[9:2];
            r_p    <= p_prod[15:8];
        end
        if (r_state == S_SF) begin
            r_sf <= sf_prod[15:8];
            r_st <= st_prod[15:8];
        end
        if (r_state == S_QT) begin
            r_q <= q_prod[15:8];
            r_t <= t_prod[15:8];
        end
        if (wb_fire) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_color.valid = r_out_valid;
    assign o_color.red   = r_red;
    assign o_color.green = r_green;
    assign o_color.blue  = r_blue;

endmodule

`default_nettype wire

// ----- rtl/hsv_light_color_controller_core.sv -----
// top level of the hsv light color controller
`default_nettype none

// Every attribute write (on/off, level, hue or saturation) on i_attr yields
// exactly one color beat on o_color, computed from all four attributes as
// they stand after that write; the color is black while the lamp is off.
// The front end updates the attributes in the cycle a write is taken and
// queues a snapshot (QUEUE_DEPTH entries), so writes are taken back to back
// until the queue fills. The back end converts one snapshot at a time in a
// six-step sequence (hue to degrees, region, in-region fraction, the
// saturation products, the level products, write-back into the output
// register) and takes no new snapshot before that write-back, which
// waits while the output register holds a color not yet taken.
// A finished color waits in the output register while the next conversion
// proceeds up to its write-back.
module hsv_light_color_controller_core #(
    parameter int QUEUE_DEPTH = hsvlc_pkg::QDEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    hsvlc_attr_if.sink    i_attr,
    hsvlc_color_if.source o_color
);

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    hsvlc_pkg::t_snap push_snap;
    hsvlc_pkg::t_snap pop_snap;

    hsvlc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_attr  (i_attr),
        .i_full  (full),
        .o_push  (push),
        .o_snap  (push_snap)
    );

    hsvlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_snap)
    );

    hsvlc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (pop_snap),
        .o_pop   (pop),
        .o_color (o_color)
    );

endmodule

`default_nettype wire

// ----- rtl/hsvlc_checker.sv -----
// port-level checks for the hsv light color controller, bound to the top
`default_nettype none

module hsvlc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_red,
    input wire [7:0] i_green,
    input wire [7:0] i_blue
);

    logic [2:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // writes taken but whose color beat is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else if (in_beat && !out_beat) begin
            r_pending <= r_pending + 3'd1;
        end else if (out_beat && !in_beat) begin
            r_pending <= r_pending - 3'd1;
        end
    end

    a_no_spurious_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 3'd0))
        else $error("color beat with no pending attribute write");

    a_bounded_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pending) <= hsvlc_pkg::QDEPTH + 2))
        else $error("more writes in flight than queue and back end hold");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("color beat withdrawn while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("color changed while stalled");

endmodule

bind hsv_light_color_controller_core hsvlc_checker u_hsvlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_attr.valid),
    .i_in_ready  (i_attr.ready),
    .i_out_valid (o_color.valid),
    .i_out_ready (o_color.ready),
    .i_red       (o_color.red),
    .i_green     (o_color.green),
    .i_blue      (o_color.blue)
);

`default_nettype wire
